// ===== design/addressable_led_strip_driver_macros.svh =====
// Assertion macros for the addressable LED strip driver.
// No dependencies; included by the top level only.
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_MACROS_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define LSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define LSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define LSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/lsd_pkg.sv =====
// Shared types and constants of the addressable LED strip driver.
// No dependencies; lsd_frame_ctl and the top level import it.
package lsd_pkg;

	localparam int MAX_LEDS       = 256;
	localparam int LED_AW         = $clog2(MAX_LEDS);
	localparam int LED_CW         = 9;
	localparam int BITS_PER_PIXEL = 24;
	localparam int BIT_W          = 5;
	localparam int SLOT_W         = 13;
	localparam int TICK_W         = 8;
	localparam int PIXEL_W        = 24;
	localparam int CFG_AW         = 3;
	localparam int CFG_DW         = 9;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_SET   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_SHOW  = 2'd3
	} action_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_BUSY  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam logic [CFG_AW-1:0] REG_NUM_LEDS    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PERIOD      = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ZERO_HIGH   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_ONE_HIGH    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RESET_SLOTS = 3'd4;

	localparam logic [LED_CW-1:0] RST_NUM_LEDS    = 9'd1;
	localparam logic [7:0]        RST_PERIOD      = 8'd40;
	localparam logic [7:0]        RST_ZERO_HIGH   = 8'd13;
	localparam logic [7:0]        RST_ONE_HIGH    = 8'd26;
	localparam logic [7:0]        RST_RESET_SLOTS = 8'd48;

	localparam logic [BIT_W-1:0]  LAST_BIT = 5'd23;

	// waveform position; led and bit_idx always equal slot / 24 and slot % 24
	typedef struct packed {
		logic              sending;
		logic [SLOT_W-1:0] slot;
		logic [LED_CW-1:0] led;
		logic [BIT_W-1:0]  bit_idx;
		logic [TICK_W-1:0] tick;
	} pos_t;

endpackage

// ===== design/lsd_cmd_if.sv =====
// Command channel of the LED strip driver: valid/ready plus one action item.
// Depends on nothing.
interface lsd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, action, pixel_index, red, green, blue, input ready);
	modport sink   (input valid, action, pixel_index, red, green, blue, output ready);
endinterface

// ===== design/lsd_res_if.sv =====
// Result channel of the LED strip driver: valid/ready plus line, busy and status.
// Depends on nothing.
interface lsd_res_if;
	logic       valid;
	logic       ready;
	logic       line;
	logic       busy_res;
	logic [1:0] status;

	modport source (output valid, line, busy_res, status, input ready);
	modport sink   (input valid, line, busy_res, status, output ready);
endinterface

// ===== design/lsd_pixel_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lsd_pixel_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 24,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/lsd_frame_ctl.sv =====
// Frame timing of the LED strip driver: tick, slot, LED and bit counters.
// Depends on lsd_pkg.
module lsd_frame_ctl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  lsd_pkg::action_t          act,
	input  logic [7:0]                period,
	input  logic [7:0]                reset_slots,
	input  logic [lsd_pkg::LED_CW-1:0] leds_used,
	output lsd_pkg::pos_t             pos_q,
	output lsd_pkg::pos_t             pos_nxt
);
	import lsd_pkg::*;

	logic [7:0]        period_eff;
	logic [SLOT_W-1:0] frame_slots;
	logic [TICK_W:0]   tick_inc;
	logic              wrap;
	pos_t              adv;

	assign period_eff  = (period == 8'd0) ? 8'd1 : period;
	assign frame_slots = SLOT_W'({leds_used, 4'b0}) + SLOT_W'({leds_used, 3'b0})
		+ SLOT_W'(reset_slots);
	assign tick_inc    = {1'b0, pos_q.tick} + 9'd1;
	assign wrap        = tick_inc >= {1'b0, period_eff};

	always_comb begin
		adv = pos_q;
		adv.tick = tick_inc[TICK_W-1:0];
		if (wrap) begin
			adv.tick = '0;
			adv.slot = pos_q.slot + 1'b1;
			if (pos_q.bit_idx == LAST_BIT) begin
				adv.bit_idx = '0;
				adv.led     = pos_q.led + 1'b1;
			end else begin
				adv.bit_idx = pos_q.bit_idx + 1'b1;
			end
		end
		// end of frame, also when the frame was shortened under us
		if (adv.slot >= frame_slots) begin
			adv = '0;
		end
	end

	always_comb begin
		pos_nxt = pos_q;
		case (act)
			ACT_TICK: begin
				if (pos_q.sending) begin
					pos_nxt = adv;
				end
			end
			ACT_SHOW: begin
				if (!pos_q.sending) begin
					pos_nxt = '0;
					pos_nxt.sending = frame_slots != '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step) begin
			pos_q <= pos_nxt;
		end
	end
endmodule

// ===== design/addressable_led_strip_driver.sv =====
// Top level of the addressable LED strip driver: config registers, pixel store, result.
// Depends on lsd_pkg, lsd_cmd_if, lsd_res_if, lsd_pixel_ram, lsd_frame_ctl and the macros.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  cmd     | in  | valid/ready        | action, pixel_index, red, green, blue
//  res     | out | valid/ready        | line, busy_res, status
//  cfg     | in  | cfg_we, no stall   | cfg_addr (register index), cfg_data
//
// Each item is accepted in ST_IDLE and finished in ST_READ: the accept cycle updates the
// timing counters, writes the pixel store and issues the read of the LED now on the wire;
// the next cycle uses the registered read data of that memory port to form the line level.
// The result register frees itself when taken, so a new item is accepted while
// the previous result waits only if it leaves in the same cycle.
// Reset clears the counters and the per-pixel valid bits and loads the config defaults;
// a pixel whose valid bit is clear reads as black, so no clearing pass is needed.
module addressable_led_strip_driver (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lsd_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [lsd_pkg::CFG_DW-1:0] cfg_data,
	lsd_cmd_if.sink                   cmd,
	lsd_res_if.source                 res
);
	import lsd_pkg::*;

	`include "addressable_led_strip_driver_macros.svh"

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LED_CW-1:0] num_leds_q;
	logic [7:0]        period_q;
	logic [7:0]        zero_high_q;
	logic [7:0]        one_high_q;
	logic [7:0]        reset_slots_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_leds_q    <= RST_NUM_LEDS;
			period_q      <= RST_PERIOD;
			zero_high_q   <= RST_ZERO_HIGH;
			one_high_q    <= RST_ONE_HIGH;
			reset_slots_q <= RST_RESET_SLOTS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NUM_LEDS:    num_leds_q    <= cfg_data;
				REG_PERIOD:      period_q      <= cfg_data[7:0];
				REG_ZERO_HIGH:   zero_high_q   <= cfg_data[7:0];
				REG_ONE_HIGH:    one_high_q    <= cfg_data[7:0];
				REG_RESET_SLOTS: reset_slots_q <= cfg_data[7:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// saturate the LED count at the store depth
	logic [LED_CW-1:0] leds_used;
	assign leds_used = (num_leds_q > LED_CW'(MAX_LEDS)) ? LED_CW'(MAX_LEDS) : num_leds_q;

	// handshake
	logic    res_vld_q;
	logic    accept;
	action_t act;

	assign cmd.ready = (state_q == ST_IDLE) && (!res_vld_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign act       = action_t'(cmd.action);

	// set_pixel only lands inside the active strip
	logic               set_ok;
	logic               ram_we;
	logic [PIXEL_W-1:0] ram_wdata;
	logic [LED_AW-1:0]  ram_raddr;
	logic [PIXEL_W-1:0] ram_rdata;
	logic [1:0]         status_d;

	pos_t pos_q;
	pos_t pos_nxt;

	assign set_ok    = (act == ACT_SET) && ({1'b0, cmd.pixel_index} < leds_used);
	assign ram_we    = accept && set_ok;
	assign ram_wdata = {cmd.green, cmd.red, cmd.blue};
	assign ram_raddr = pos_nxt.led[LED_AW-1:0];

	always_comb begin
		status_d = STATUS_OK;
		if (act == ACT_SHOW && pos_q.sending) begin
			status_d = STATUS_BUSY;
		end else if (act == ACT_SET && !set_ok) begin
			status_d = STATUS_RANGE;
		end
	end

	lsd_frame_ctl u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.act         (act),
		.period      (period_q),
		.reset_slots (reset_slots_q),
		.leds_used   (leds_used),
		.pos_q       (pos_q),
		.pos_nxt     (pos_nxt)
	);

	lsd_pixel_ram #(
		.DEPTH (MAX_LEDS),
		.WIDTH (PIXEL_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.pixel_index),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// per-pixel valid bits: clear drops the active range, set_pixel marks one
	logic [MAX_LEDS-1:0] pix_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_q <= '0;
		end else if (accept) begin
			if (ram_we) begin
				pix_vld_q[cmd.pixel_index] <= 1'b1;
			end
			if (act == ACT_CLEAR) begin
				for (int k = 0; k < MAX_LEDS; k++) begin
					if (LED_CW'(k) < leds_used) begin
						pix_vld_q[k] <= 1'b0;
					end
				end
			end
		end
	end

	// forward a write that hits the address read in the same cycle
	logic               fwd_s1;
	logic [PIXEL_W-1:0] wdata_s1;
	logic [1:0]         status_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1    <= ram_we && (cmd.pixel_index == ram_raddr);
			wdata_s1  <= ram_wdata;
			status_s1 <= status_d;
		end
	end

	// line level at the new waveform position
	logic [PIXEL_W-1:0] pix;
	logic [BIT_W-1:0]   bitpos;
	logic [7:0]         duty;
	logic               line_d;

	always_comb begin
		if (fwd_s1) begin
			pix = wdata_s1;
		end else if (pix_vld_q[pos_q.led[LED_AW-1:0]]) begin
			pix = ram_rdata;
		end else begin
			pix = '0;
		end
		bitpos = LAST_BIT - pos_q.bit_idx;
		duty   = pix[bitpos] ? one_high_q : zero_high_q;
		line_d = pos_q.sending && (pos_q.led < leds_used) && (pos_q.tick < duty);
	end

	// sequencer and result register
	logic       res_line_q;
	logic       res_busy_q;
	logic [1:0] res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_vld_q    <= 1'b0;
			res_line_q   <= 1'b0;
			res_busy_q   <= 1'b0;
			res_status_q <= STATUS_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (res_vld_q && res.ready) begin
						res_vld_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// result register is free here: accept required it
					res_vld_q    <= 1'b1;
					res_line_q   <= line_d;
					res_busy_q   <= pos_q.sending;
					res_status_q <= status_s1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid    = res_vld_q;
	assign res.line     = res_line_q;
	assign res.busy_res = res_busy_q;
	assign res.status   = res_status_q;

	// checks
	`LSD_ASSERT_NOW(a_line_needs_busy, clk, arst_n, res.valid && res.line, res.busy_res, "line high while not busy")
	`LSD_ASSERT_NOW(a_status_code, clk, arst_n, res.valid, res.status != 2'd3, "undefined status code")
	`LSD_ASSERT_NXT(a_one_item_at_a_time, clk, arst_n, accept, !cmd.ready && res.valid == $past(res_vld_q && !res.ready), "item overlap in sequencer")
	`LSD_ASSERT_NXT(a_idle_frame_quiet, clk, arst_n, accept && !pos_q.sending && act == ACT_TICK, !pos_q.sending, "tick started a frame")
endmodule

// ===== sim/tb_addressable_led_strip_driver.sv =====
// Self-checking bench for addressable_led_strip_driver: drives actions and register
// writes, predicts line level, busy and status per item and compares them in order.
// Depends on lsd_pkg, lsd_cmd_if, lsd_res_if and the driver RTL.
module tb_addressable_led_strip_driver;
	timeunit 1ns;
	timeprecision 1ps;

	import lsd_pkg::*;

	localparam int unsigned PHASES         = 7;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned CYCLE_LIMIT    = 500000;
	localparam int unsigned HOLD_AFTER     = 250;
	localparam int unsigned HOLD_CYCLES    = 120;
	localparam int unsigned MAX_REPORTS    = 100;
	// index 5..7 is not a register; writes there must fall on the floor
	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		action_t    act;
		logic [7:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} strip_cmd_t;

	typedef struct packed {
		logic       line;
		logic       busy_res;
		logic [1:0] status;
	} strip_res_t;

	// one row of the directed plan: a register write or an action item
	typedef struct {
		bit                 is_cfg;
		logic [CFG_AW-1:0]  reg_idx;
		logic [CFG_DW-1:0]  reg_val;
		strip_cmd_t         cmd;
		bit                 chk;
		strip_res_t         want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_addr;
	logic [CFG_DW-1:0]   cfg_data;

	lsd_cmd_if cmd_bus ();
	lsd_res_if res_bus ();

	addressable_led_strip_driver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cmd      (cmd_bus),
		.res      (res_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Strip model: pixel store, frame position and register copies
	// ------------------------------------------------------------------
	logic [PIXEL_W-1:0] pix_mem [MAX_LEDS];
	bit                 fr_active = 1'b0;
	int unsigned        fr_slot = 0;
	int unsigned        fr_tick = 0;
	logic [8:0]         r_num = RST_NUM_LEDS;
	logic [7:0]         r_period = RST_PERIOD;
	logic [7:0]         r_zero = RST_ZERO_HIGH;
	logic [7:0]         r_one = RST_ONE_HIGH;
	logic [7:0]         r_latch = RST_RESET_SLOTS;

	strip_res_t  wire_forecast [$];
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned reports = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;

	initial begin
		for (int k = 0; k < MAX_LEDS; k++)
			pix_mem[k] = '0;
	end

	// the store only holds MAX_LEDS pixels; a larger count saturates
	function automatic int unsigned leds_eff();
		return (r_num > MAX_LEDS) ? MAX_LEDS : int'(r_num);
	endfunction

	function automatic int unsigned data_len();
		return leds_eff() * BITS_PER_PIXEL;
	endfunction

	function automatic int unsigned frame_len();
		return data_len() + r_latch;
	endfunction

	// a zero period behaves as one tick per slot
	function automatic int unsigned period_eff();
		return (r_period == 8'd0) ? 1 : int'(r_period);
	endfunction

	// level at the current frame position; latch slots and idle are low
	function automatic logic wire_level();
		int unsigned led;
		int unsigned bp;
		int unsigned duty;
		if (!fr_active || fr_slot >= data_len())
			return 1'b0;
		led  = fr_slot / BITS_PER_PIXEL;
		bp   = 23 - (fr_slot % BITS_PER_PIXEL);
		duty = pix_mem[led][bp] ? r_one : r_zero;
		return (fr_tick < duty);
	endfunction

	function automatic void apply_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
		case (a)
			REG_NUM_LEDS:    r_num = d;
			REG_PERIOD:      r_period = d[7:0];
			REG_ZERO_HIGH:   r_zero = d[7:0];
			REG_ONE_HIGH:    r_one = d[7:0];
			REG_RESET_SLOTS: r_latch = d[7:0];
			default: ;
		endcase
	endfunction

	// advance the strip by one accepted item and return what the block reports
	function automatic strip_res_t advance_strip(strip_cmd_t c);
		strip_res_t r;
		r.status = STATUS_OK;
		case (c.act)
			ACT_TICK: begin
				if (fr_active) begin
					fr_tick++;
					if (fr_tick >= period_eff()) begin
						fr_tick = 0;
						fr_slot++;
					end
					// also ends a frame that shrank under the current slot
					if (fr_slot >= frame_len()) begin
						fr_active = 1'b0;
						fr_slot   = 0;
						fr_tick   = 0;
					end
				end
			end
			ACT_SET: begin
				if (c.idx >= leds_eff())
					r.status = STATUS_RANGE;
				else
					pix_mem[c.idx] = {c.green, c.red, c.blue};
			end
			ACT_CLEAR: begin
				for (int unsigned k = 0; k < leds_eff(); k++)
					pix_mem[k] = '0;
			end
			default: begin
				if (fr_active) begin
					r.status = STATUS_BUSY;
				end else begin
					fr_slot   = 0;
					fr_tick   = 0;
					// an empty frame is accepted but never starts
					fr_active = (frame_len() > 0);
				end
			end
		endcase
		r.line     = wire_level();
		r.busy_res = fr_active;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic row_t item_row(action_t a, logic [7:0] i, logic [7:0] rd,
			logic [7:0] gr, logic [7:0] bl, bit chk = 1'b0, logic ln = 1'b0,
			logic bz = 1'b0, logic [1:0] st = STATUS_OK);
		row_t r;
		r.is_cfg        = 1'b0;
		r.reg_idx       = REG_NUM_LEDS;
		r.reg_val       = '0;
		r.cmd           = '{act: a, idx: i, red: rd, green: gr, blue: bl};
		r.chk           = chk;
		r.want.line     = ln;
		r.want.busy_res = bz;
		r.want.status   = st;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
		row_t r;
		r        = item_row(ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
		r.is_cfg = 1'b1;
		r.reg_idx = a;
		r.reg_val = d;
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(bit burst);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// bias toward ticks while a frame runs so frames reach their end;
	// toward set and show while idle so new frames get built
	function automatic strip_cmd_t random_cmd();
		strip_cmd_t  c;
		int unsigned roll;
		int unsigned used;
		roll  = $urandom_range(0, 99);
		used  = leds_eff();
		c.idx   = 8'($urandom_range(0, 255));
		c.red   = 8'($urandom_range(0, 255));
		c.green = 8'($urandom_range(0, 255));
		c.blue  = 8'($urandom_range(0, 255));
		if (fr_active)
			c.act = (roll < 80) ? ACT_TICK : (roll < 92) ? ACT_SET :
				(roll < 95) ? ACT_CLEAR : ACT_SHOW;
		else
			c.act = (roll < 15) ? ACT_TICK : (roll < 55) ? ACT_SET :
				(roll < 62) ? ACT_CLEAR : ACT_SHOW;
		// keep most writes inside the strip, leave some out of range
		if (c.act == ACT_SET && used > 0 && $urandom_range(0, 9) < 8)
			c.idx = 8'($urandom_range(0, used - 1));
		return c;
	endfunction

	// offer one item, hold it until taken, then record the forecast
	task automatic offer(strip_cmd_t c, bit chk, strip_res_t want);
		int unsigned gap;
		strip_res_t  got;
		gap = pick_gap(tx_burst);
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.action      <= c.act;
		cmd_bus.pixel_index <= c.idx;
		cmd_bus.red         <= c.red;
		cmd_bus.green       <= c.green;
		cmd_bus.blue        <= c.blue;
		do @(posedge clk); while (!cmd_bus.ready);
		got = advance_strip(c);
		wire_forecast.push_back(chk ? want : got);
		items_sent++;
		if (items_sent % 50 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
	endtask

	// drop valid and wait until every forecast result has been taken
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (wire_forecast.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write; the write lands at the next edge, then release we
	task automatic wr_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
		cfg_we   <= 1'b1;
		cfg_addr <= a;
		cfg_data <= d;
		@(posedge clk);
		apply_reg(a, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report(string what, logic [1:0] e, logic [1:0] a);
		mismatches++;
		if (reports < MAX_REPORTS) begin
			reports++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
		end
	endtask

	// ------------------------------------------------------------------
	// Result check: compare every taken item against the oldest forecast
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		strip_res_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen++;
			if (wire_forecast.size() == 0) begin
				report("unexpected result", 2'd0, {1'b0, res_bus.line});
			end else begin
				want = wire_forecast.pop_front();
				if (res_bus.line !== want.line)
					report("line", {1'b0, want.line}, {1'b0, res_bus.line});
				if (res_bus.busy_res !== want.busy_res)
					report("busy_res", {1'b0, want.busy_res}, {1'b0, res_bus.busy_res});
				if (res_bus.status !== want.status)
					report("status", want.status, res_bus.status);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, burst stretches, one long hold-off
	// ------------------------------------------------------------------
	initial begin
		int unsigned rx_iter;
		bit          held;
		rx_iter = 0;
		held    = 1'b0;
		res_bus.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				// hold off long enough for the block to fill and stall its input
				held = 1'b1;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!rx_burst && $urandom_range(0, 99) < 25) begin
				res_bus.ready <= 1'b0;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
					$urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_bus.ready <= 1'b1;
				@(posedge clk);
			end
			rx_iter++;
			if (rx_iter % 64 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, directed plan, then randomized phases
	// ------------------------------------------------------------------
	initial begin
		row_t        plan [$];
		row_t        row;
		int unsigned n;
		int unsigned per;
		int unsigned zh;
		int unsigned oh;
		int unsigned lat;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_addr            <= REG_NUM_LEDS;
		cfg_data            <= '0;
		cmd_bus.valid       <= 1'b0;
		cmd_bus.action      <= ACT_TICK;
		cmd_bus.pixel_index <= '0;
		cmd_bus.red         <= '0;
		cmd_bus.green       <= '0;
		cmd_bus.blue        <= '0;

		// Directed plan under reset registers: one LED, 40-tick slots.
		// Tick while idle changes nothing.
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00,
			1'b1, 1'b0, 1'b0, STATUS_OK));
		plan.push_back(item_row(ACT_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF,
			1'b1, 1'b0, 1'b0, STATUS_OK));
		// Index at or above the LED count is refused.
		plan.push_back(item_row(ACT_SET, 8'd255, 8'h00, 8'h00, 8'h00,
			1'b1, 1'b0, 1'b0, STATUS_RANGE));
		plan.push_back(item_row(ACT_SET, 8'd1, 8'h12, 8'h34, 8'h56,
			1'b1, 1'b0, 1'b0, STATUS_RANGE));
		// Show lands on slot 0 tick 0 of a white pixel: line high at once.
		plan.push_back(item_row(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00,
			1'b1, 1'b1, 1'b1, STATUS_OK));
		// Show while busy is ignored.
		plan.push_back(item_row(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00,
			1'b1, 1'b1, 1'b1, STATUS_BUSY));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
		// Clear and set mid-frame change the bits not yet sent.
		plan.push_back(item_row(ACT_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_SET, 8'd0, 8'hFF, 8'h00, 8'h00));
		// Zero period acts as one tick per slot; drop the latch slots.
		plan.push_back(cfg_row(REG_PERIOD, 9'd0));
		plan.push_back(cfg_row(REG_RESET_SLOTS, 9'd0));
		plan.push_back(cfg_row(REG_UNUSED, 9'h1FF));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
		// Shrink the frame under the current slot: it ends on the next tick.
		plan.push_back(cfg_row(REG_NUM_LEDS, 9'd0));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00,
			1'b1, 1'b0, 1'b0, STATUS_OK));
		// Empty frame: accepted but never busy.
		plan.push_back(item_row(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00,
			1'b1, 1'b0, 1'b0, STATUS_OK));
		plan.push_back(item_row(ACT_SET, 8'd0, 8'hAA, 8'h55, 8'hFF,
			1'b1, 1'b0, 1'b0, STATUS_RANGE));
		// LED count above the store saturates, so the top pixel is writable.
		plan.push_back(cfg_row(REG_NUM_LEDS, 9'h1FF));
		plan.push_back(item_row(ACT_SET, 8'd255, 8'h5A, 8'hA5, 8'h3C,
			1'b1, 1'b0, 1'b0, STATUS_OK));
		// Extremes: longest slot, duty equal to the period for zeros, no high time for ones.
		plan.push_back(cfg_row(REG_PERIOD, 9'd255));
		plan.push_back(cfg_row(REG_ZERO_HIGH, 9'd255));
		plan.push_back(cfg_row(REG_ONE_HIGH, 9'd0));
		plan.push_back(cfg_row(REG_RESET_SLOTS, 9'd255));
		plan.push_back(item_row(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_SET, 8'd0, 8'h00, 8'hFF, 8'h00));
		plan.push_back(item_row(ACT_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
		plan.push_back(item_row(ACT_SET, 8'd128, 8'h81, 8'h7E, 8'hC3));

		// hold reset, then release it on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed plan; register writes wait for the block to drain
		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg) begin
				settle();
				wr_reg(row.reg_idx, row.reg_val);
			end else begin
				offer(row.cmd, row.chk, row.want);
			end
		end

		// randomized phases, each with its own register set
		for (int unsigned p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin
					// shortest useful frame: one LED, one tick per slot
					n = 1; per = 1; zh = 0; oh = 1; lat = 2;
				end
				2: begin
					// full strip: reach the upper pixel indexes
					n = MAX_LEDS; per = 1; zh = 1; oh = 0; lat = $urandom_range(0, 255);
				end
				4: begin
					// both duties above the period: line high through all data
					n = 2; per = 2; zh = 255; oh = 255; lat = 1;
				end
				default: begin
					n   = $urandom_range(0, 3);
					per = $urandom_range(0, 4);
					zh  = $urandom_range(0, per + 1);
					oh  = $urandom_range(0, per + 1);
					lat = $urandom_range(0, 6);
				end
			endcase
			wr_reg(REG_NUM_LEDS, CFG_DW'(n));
			wr_reg(REG_PERIOD, CFG_DW'(per));
			wr_reg(REG_ZERO_HIGH, CFG_DW'(zh));
			wr_reg(REG_ONE_HIGH, CFG_DW'(oh));
			wr_reg(REG_RESET_SLOTS, CFG_DW'(lat));
			repeat (ITEMS_PER_PHASE)
				offer(random_cmd(), 1'b0, '0);
		end

		// drain everything still in flight, then give the verdict
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && wire_forecast.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
